[hdl/tfp_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the telemetry frame parser.
package tfp_pkg;

	localparam logic [7:0] StartByteDefault = 8'hA5;
	localparam logic [7:0] CrcPoly          = 8'h07;
	localparam logic [7:0] CrcTopBit        = 8'h80;
	localparam logic [7:0] MinPayload       = 8'd6;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TRUNC    = 3'd1,
		ST_BADSTART = 3'd2,
		ST_BADCRC   = 3'd3,
		ST_SHORT    = 3'd4
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] timestamp;
		logic [15:0] reading;
	} result_t;

	// One byte through CRC-8/ATM, most significant bit first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if ((c & CrcTopBit) != 8'd0) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

[hdl/telemetry_frame_parser_crc8.sv]
// Top level of the telemetry frame parser with CRC-8/ATM check.
// Usage:
// The input channel (in_valid/in_ready) carries one buffer byte per transaction,
// with buffer_end set on the last byte of a buffer. The output channel
// (out_valid/out_ready) carries one result transaction per buffer: status,
// timestamp and reading. Fields other than status are zero unless status is ok.
// Each accepted byte is held in an input register, then the frame logic updates
// its state; the last byte's result lands in the output register. A last byte
// passes the input and then the output register before out_valid rises. One byte
// is taken per cycle while in_ready is high. When the receiver stalls, bytes that
// end no buffer keep flowing; a last byte waits in the input register, and
// in_ready drops only while it waits there. The user writes start_byte through
// start_byte_we/start_byte_wdata only while idle; the block does not enforce it.
// Reset clears both valid flags and the frame state and sets start_byte to 0xA5.
module telemetry_frame_parser_crc8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] timestamp,
	output logic [15:0] reading,
	input  logic        start_byte_we,
	input  logic [7:0]  start_byte_wdata
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              end_s1;
	logic              s1_go;
	logic              out_free;
	logic [7:0]        start_byte_q;
	logic              out_valid_q;
	tfp_pkg::result_t  result;
	tfp_pkg::result_t  result_q;

	assign out_free = !out_valid_q || out_ready;
	assign s1_go    = valid_s1 && (!end_s1 || out_free);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= tfp_pkg::StartByteDefault;
		end else if (start_byte_we) begin
			start_byte_q <= start_byte_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			end_s1  <= buffer_end;
		end
	end

	tfp_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (s1_go),
		.data_byte  (data_s1),
		.buffer_end (end_s1),
		.start_byte (start_byte_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && end_s1) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = result_q.status;
	assign timestamp = result_q.timestamp;
	assign reading   = result_q.reading;

`ifndef SYNTHESIS
	// A result only ever follows a last byte that sat in the input register.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && end_s1))
		else $error("result appeared without a buffer end");

	// A waiting last byte must not be lost while the output is blocked.
	a_end_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && end_s1 && out_valid_q && !out_ready) |=> (valid_s1 && end_s1))
		else $error("last byte dropped while output stalled");

	// Only an ok result carries captured fields.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.status != tfp_pkg::ST_OK)
			|-> (result_q.timestamp == 32'd0 && result_q.reading == 16'd0))
		else $error("non-ok result carries field data");
`endif

endmodule

[hdl/tfp_frame.sv]
// Per-buffer frame state: position, length, running CRC and field captures.
module tfp_frame (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              buffer_end,
	input  logic [7:0]        start_byte,
	output tfp_pkg::result_t  result
);

	tfp_pkg::status_t outcome_q, outcome_nxt;
	logic [8:0]       position_q, position_nxt;
	logic [7:0]       length_q, length_nxt;
	logic [7:0]       crc_q, crc_nxt;
	logic [31:0]      ts_q, ts_nxt;
	logic [15:0]      val_q, val_nxt;
	logic [8:0]       frame_end;
	logic [8:0]       offset;

	assign frame_end = {1'b0, length_q} + 9'd2;
	assign offset    = position_q - 9'd2;

	always_comb begin
		outcome_nxt  = outcome_q;
		length_nxt   = length_q;
		crc_nxt      = crc_q;
		ts_nxt       = ts_q;
		val_nxt      = val_q;
		position_nxt = position_q;
		if (outcome_q == tfp_pkg::ST_TRUNC) begin
			if (position_q == 9'd0) begin
				if (data_byte != start_byte) begin
					outcome_nxt = tfp_pkg::ST_BADSTART;
				end
			end else if (position_q == 9'd1) begin
				length_nxt = data_byte;
			end else if (position_q < frame_end) begin
				crc_nxt = tfp_pkg::crc8_byte(crc_q, data_byte);
				if (offset < 9'd4) begin
					ts_nxt = {ts_q[23:0], data_byte};
				end else if (offset < 9'd6) begin
					val_nxt = {val_q[7:0], data_byte};
				end
			end else begin
				// The byte after the payload is the CRC byte and settles the outcome.
				if (data_byte != crc_q) begin
					outcome_nxt = tfp_pkg::ST_BADCRC;
				end else if (length_q < tfp_pkg::MinPayload) begin
					outcome_nxt = tfp_pkg::ST_SHORT;
				end else begin
					outcome_nxt = tfp_pkg::ST_OK;
				end
			end
			if (outcome_nxt == tfp_pkg::ST_TRUNC || position_q < 9'd2) begin
				position_nxt = position_q + 9'd1;
			end
		end
	end

	always_comb begin
		result.status = outcome_nxt;
		if (outcome_nxt == tfp_pkg::ST_OK) begin
			result.timestamp = ts_nxt;
			result.reading   = val_nxt;
		end else begin
			result.timestamp = 32'd0;
			result.reading   = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outcome_q  <= tfp_pkg::ST_TRUNC;
			position_q <= 9'd0;
			length_q   <= 8'd0;
			crc_q      <= 8'd0;
			ts_q       <= 32'd0;
			val_q      <= 16'd0;
		end else if (step) begin
			if (buffer_end) begin
				outcome_q  <= tfp_pkg::ST_TRUNC;
				position_q <= 9'd0;
				length_q   <= 8'd0;
				crc_q      <= 8'd0;
				ts_q       <= 32'd0;
				val_q      <= 16'd0;
			end else begin
				outcome_q  <= outcome_nxt;
				position_q <= position_nxt;
				length_q   <= length_nxt;
				crc_q      <= crc_nxt;
				ts_q       <= ts_nxt;
				val_q      <= val_nxt;
			end
		end
	end

endmodule
